@@ hw/rtl/dec96_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec96_pkg
// Shared types and constants for the 96-bit decimal integer rounding unit.
// ----------------------------------------------------------------------------
package dec96_pkg;

    localparam int MANT_W      = 96;
    localparam int CHUNK_W     = 16;
    localparam int NUM_CHUNKS  = MANT_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS);
    localparam int DIGIT_W     = 4;
    localparam int CUR_W       = DIGIT_W + CHUNK_W;
    localparam int SCALE_W     = 5;
    localparam int OP_W        = 2;
    localparam int MAX_SCALE   = 28;

    // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every x below 10 * 65536
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(838861);
    localparam int PROD_W      = CUR_W + RECIP_W;

    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 104;
    localparam int OUT_USED_W  = MANT_W + SCALE_W + 1;

    localparam logic [DIGIT_W-1:0] DIGIT_HALF = DIGIT_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_NEG   = 2'd0,
        OP_TRUNC = 2'd1,
        OP_FLOOR = 2'd2,
        OP_ROUND = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADJ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [CHUNK_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_res;

endpackage

`default_nettype wire

@@ hw/rtl/decimal96_integer_rounding_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal96_integer_rounding_unit
// Negate, truncate, floor or round-half-even of a 96-bit scaled decimal.
//
// Input item on s_axis: opcode, 96-bit mantissa, scale 0..28 and sign.
// Result item on m_axis: 96-bit mantissa, scale and sign; zero is positive.
// The mantissa is divided by ten once per scale step, 16 bits per cycle
// through one shared divide-by-ten unit. Truncate, floor and round pass
// through ST_DIV for every scale step and then ST_ADJ before the result is
// valid (scales above 28 count as 28); negate or scale 0 goes from accept
// straight to ST_ADJ. One item is in flight at a time; a new item
// is taken in the cycle its predecessor's result is taken.
// The result stays on m_axis until m_axis_tready; a stalled receiver holds
// the block. Synchronous reset drops any item in flight and leaves the
// block idle and ready.
// ----------------------------------------------------------------------------
module decimal96_integer_rounding_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // opcode, mant_lo, mant_hi, scale, sign_in
    input  wire logic [dec96_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // res_lo, res_hi, res_scale, res_sign, zero fill
    output logic [dec96_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready
);
    import dec96_pkg::*;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [MANT_W-1:0]      r_work;
    logic                   r_sign;
    logic [SCALE_W-1:0]     r_scale;
    logic [SCALE_W-1:0]     r_digits;
    logic [CHUNK_CNT_W-1:0] r_chunk;
    logic [DIGIT_W-1:0]     r_rem;
    logic [DIGIT_W-1:0]     r_first;
    logic                   r_sticky;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                   w_accept;
    logic                   w_step;
    logic                   w_adj;
    t_op                    w_in_op;
    logic [SCALE_W-1:0]     w_in_scale_raw;
    logic [SCALE_W-1:0]     w_in_scale;
    logic                   w_in_direct;
    logic                   w_last_chunk;
    t_div_res               w_div;
    logic                   w_inc;
    logic [MANT_W-1:0]      w_res;
    logic                   w_res_zero;
    logic                   w_res_sign;
    logic [SCALE_W-1:0]     w_res_scale;

    assign w_in_op        = t_op'(s_axis_tdata[OP_W-1:0]);
    assign w_in_scale_raw = s_axis_tdata[OP_W+MANT_W +: SCALE_W];
    assign w_in_scale     = (w_in_scale_raw > SCALE_W'(MAX_SCALE)) ?
                            SCALE_W'(MAX_SCALE) : w_in_scale_raw;
    assign w_in_direct    = (w_in_op == OP_NEG) || (w_in_scale == '0);
    assign w_last_chunk   = (r_chunk == CHUNK_CNT_W'(NUM_CHUNKS - 1));
    assign w_accept       = s_axis_tvalid && s_axis_tready;

    dec96_div10 u_div10 (
        .i_cur (CUR_W'({r_rem, r_work[MANT_W-1 -: CHUNK_W]})),
        .o_res (w_div)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_direct ? ST_ADJ : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_last_chunk && (r_digits == SCALE_W'(1))) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_accept) begin
                    n_state = w_in_direct ? ST_ADJ : ST_DIV;
                end else if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_step        = 1'b0;
        w_adj         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_DIV: begin
                w_step = 1'b1;
            end
            ST_ADJ: begin
                w_adj = 1'b1;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                s_axis_tready = m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_inc = 1'b0;
        case (r_op)
            OP_FLOOR: begin
                w_inc = r_sign && ((r_first != '0) || r_sticky);
            end
            OP_ROUND: begin
                w_inc = (r_first > DIGIT_HALF) ||
                        ((r_first == DIGIT_HALF) && (r_sticky || r_work[0]));
            end
            default: begin
                w_inc = 1'b0;
            end
        endcase
        w_res       = r_work + MANT_W'(w_inc);
        w_res_zero  = (w_res == '0);
        w_res_sign  = ((r_op == OP_NEG) ? !r_sign : r_sign) && !w_res_zero;
        w_res_scale = (r_op == OP_NEG) ? r_scale : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= w_in_op;
            r_work   <= s_axis_tdata[OP_W +: MANT_W];
            r_scale  <= w_in_scale;
            r_sign   <= s_axis_tdata[OP_W+MANT_W+SCALE_W];
            r_digits <= w_in_scale;
            r_chunk  <= '0;
            r_rem    <= '0;
            r_first  <= '0;
            r_sticky <= 1'b0;
        end else if (w_step) begin
            r_work <= {r_work[MANT_W-CHUNK_W-1:0], w_div.quot};
            if (w_last_chunk) begin
                r_chunk  <= '0;
                r_rem    <= '0;
                r_first  <= w_div.rem;
                r_sticky <= r_sticky || (r_first != '0);
                r_digits <= r_digits - SCALE_W'(1);
            end else begin
                r_chunk <= r_chunk + CHUNK_CNT_W'(1);
                r_rem   <= w_div.rem;
            end
        end
        if (w_adj) begin
            r_out_data <= OUT_DATA_W'({w_res_sign, w_res_scale, w_res});
        end
    end

    assign m_axis_tdata = r_out_data;

    a_div_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !s_axis_tready)
        else $error("input taken while dividing");

    a_chunk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_chunk < CHUNK_CNT_W'(NUM_CHUNKS)) && (r_rem < 4'd10))
        else $error("chunk counter or remainder out of range");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADJ) |-> (r_first < 4'd10))
        else $error("dropped digit out of range");

    a_zero_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[MANT_W-1:0] == '0)) |->
            !m_axis_tdata[OUT_USED_W-1])
        else $error("zero result with negative sign");

endmodule

`default_nettype wire

@@ hw/rtl/dec96_div10.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec96_div10
// Divides one 16-bit chunk, with the running remainder above it, by ten.
// ----------------------------------------------------------------------------
module dec96_div10 (
    input  wire logic [dec96_pkg::CUR_W-1:0] i_cur,
    output dec96_pkg::t_div_res              o_res
);
    import dec96_pkg::*;

    logic [PROD_W-1:0]  w_prod;
    logic [CHUNK_W-1:0] w_quot;
    logic [CUR_W-1:0]   w_back;

    always_comb begin
        w_prod      = PROD_W'(i_cur) * PROD_W'(RECIP);
        w_quot      = w_prod[RECIP_SHIFT +: CHUNK_W];
        w_back      = (CUR_W'(w_quot) << 3) + (CUR_W'(w_quot) << 1);
        o_res.quot  = w_quot;
        o_res.rem   = DIGIT_W'(i_cur - w_back);
    end

endmodule

`default_nettype wire
